// ===== rtl/assert_macros.svh =====
// Assertion helpers, clocked on clk_i with reset held off.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define SLB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next.
`define SLB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/slb_pkg.sv =====
`default_nettype none
package slb_pkg;

  localparam int unsigned NODES    = 16;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned NCNT_W   = 5;
  localparam int unsigned STEP_W   = 13;
  localparam int unsigned WRR_LAPS = 258;

  localparam logic [1:0] CMD_UPDATE = 2'd0;
  localparam logic [1:0] CMD_SELECT = 2'd1;
  localparam logic [1:0] CMD_RESET  = 2'd2;

  localparam logic [2:0] POL_RR   = 3'd0;
  localparam logic [2:0] POL_WRR  = 3'd1;
  localparam logic [2:0] POL_LC   = 3'd2;
  localparam logic [2:0] POL_WLC  = 3'd3;
  localparam logic [2:0] POL_LV   = 3'd4;
  localparam logic [2:0] POL_WLV  = 3'd5;
  localparam logic [2:0] POL_HASH = 3'd6;

  localparam logic [1:0] CFG_POLICY = 2'd0;
  localparam logic [1:0] CFG_NODES  = 2'd1;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] slot;
    logic             act;
    logic [7:0]       weight;
    logic [15:0]      conn;
    logic [15:0]      load;
  } tbl_wr_t;

  typedef struct packed {
    logic        act;
    logic [7:0]  weight;
    logic [15:0] conn;
    logic [15:0] load;
  } tbl_rd_t;

endpackage
`default_nettype wire

// ===== rtl/slb_table.sv =====
`default_nettype none
// Node table: flags reset, payload undefined until written; one read port.
module slb_table (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire slb_pkg::tbl_wr_t         wr_i,
  input  wire logic [slb_pkg::IDX_W-1:0] rd_addr_i,
  output slb_pkg::tbl_rd_t              rd_o
);

  logic        act_q  [slb_pkg::NODES];
  logic [7:0]  wgt_q  [slb_pkg::NODES];
  logic [15:0] conn_q [slb_pkg::NODES];
  logic [15:0] load_q [slb_pkg::NODES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < slb_pkg::NODES; i++) act_q[i] <= 1'b0;
    end else if (wr_i.en) begin
      act_q[wr_i.slot] <= wr_i.act;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      wgt_q[wr_i.slot]  <= wr_i.weight;
      conn_q[wr_i.slot] <= wr_i.conn;
      load_q[wr_i.slot] <= wr_i.load;
    end
  end

  assign rd_o.act    = act_q[rd_addr_i];
  assign rd_o.weight = wgt_q[rd_addr_i];
  assign rd_o.conn   = conn_q[rd_addr_i];
  assign rd_o.load   = load_q[rd_addr_i];

endmodule
`default_nettype wire

// ===== rtl/slb_modn.sv =====
`default_nettype none
// Bit-serial remainder of a 32-bit value by a node count, one bit a cycle.
module slb_modn (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [31:0]                dvd_i,
  input  wire logic [slb_pkg::NCNT_W-1:0] div_i,
  output logic                            done_o,
  output logic [slb_pkg::IDX_W-1:0]       rem_o
);

  logic [31:0]               dvd_q, dvd_d;
  logic [slb_pkg::IDX_W-1:0] rem_q, rem_d;
  logic [4:0]                cnt_q, cnt_d;
  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [slb_pkg::NCNT_W-1:0] trial;

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, dvd_q[31]};
    if (start_i) begin
      dvd_d  = dvd_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = (trial >= div_i) ? slb_pkg::IDX_W'(trial - div_i)
                               : slb_pkg::IDX_W'(trial);
      dvd_d = {dvd_q[30:0], 1'b0};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvd_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      dvd_q  <= dvd_d;
      rem_q  <= rem_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

// ===== rtl/slb_gcd.sv =====
`default_nettype none
// Subtractive gcd of two 8-bit values, one subtract or swap a cycle.
module slb_gcd (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic [7:0] a_i,
  input  wire logic [7:0] b_i,
  output logic            done_o,
  output logic [7:0]      g_o
);

  logic [7:0] a_q, a_d, b_q, b_d;
  logic       busy_q, busy_d, done_q, done_d;

  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d    = a_i;
      b_d    = b_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q == 8'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else if (a_q >= b_q) begin
        a_d = a_q - b_q;
      end else begin
        a_d = b_q;
        b_d = a_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= '0;
      b_q    <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      a_q    <= a_d;
      b_q    <= b_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign done_o = done_q;
  assign g_o    = a_q;

endmodule
`default_nettype wire

// ===== rtl/server_load_balancer_select.sv =====
// Channel | Signals                                        | Beat when
// cfg     | cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i | valid & ready
// in      | in_valid_i/in_ready_o, command_i .. hash_value_i  | valid & ready
// out     | out_valid_o/out_ready_i, found_o, chosen_node_o   | valid & ready
//
// One command at a time; update, reset and no-op commands go straight to the result.
// rr and hash: the remainder unit gives the start entry, then entries are scanned in turn.
// lc/lv: a downward scan, one entry at a time; weighted forms multiply, then compare.
// wrr: a remainder pass, then index steps (up to n*258 steps), plus a gcd pass
// (subtractive unit, one entry at a time) and a max pass when caches are cold.
// Reset is asynchronous, active low; no clearing pass. A finished result waits in
// the output register while the next command is taken; a stalled output holds
// only the final hand-off.
`default_nettype none
module server_load_balancer_select (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [3:0]  node_slot_i,
  input  wire logic        node_enabled_i,
  input  wire logic [7:0]  node_weight_in_i,
  input  wire logic [15:0] node_conn_in_i,
  input  wire logic [15:0] node_load_in_i,
  input  wire logic [31:0] hash_value_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             found_o,
  output logic [3:0]       chosen_node_o
);

  localparam int unsigned IW = slb_pkg::IDX_W;
  localparam int unsigned NW = slb_pkg::NCNT_W;
  localparam int unsigned SW = slb_pkg::STEP_W;

  typedef enum logic [12:0] {
    ST_IDLE    = 13'b0000000000001,
    ST_MOD     = 13'b0000000000010,
    ST_SCAN    = 13'b0000000000100,
    ST_WRR_Z   = 13'b0000000001000,
    ST_GCD_LD  = 13'b0000000010000,
    ST_GCD_RUN = 13'b0000000100000,
    ST_WRR_CW  = 13'b0000001000000,
    ST_MAX     = 13'b0000010000000,
    ST_WRR_CHK = 13'b0000100000000,
    ST_MIN_A   = 13'b0001000000000,
    ST_MIN_B   = 13'b0010000000000,
    ST_MIN_NX  = 13'b0100000000000,
    ST_DONE    = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  // configuration and scheduler state
  logic [2:0]    mode_q, mode_d;
  logic [NW-1:0] ncnt_q, ncnt_d;
  logic [IW-1:0] last_q, last_d;
  logic [8:0]    cw_q, cw_d;
  logic [7:0]    gcd_q, gcd_d, maxw_q, maxw_d;
  logic          gval_q, gval_d, mval_q, mval_d;

  // working registers of the sequencer
  logic [IW-1:0]      idx_q, idx_d, sidx_q, sidx_d, best_q, best_d;
  logic [SW-1:0]      cnt_q, cnt_d;
  logic               have_q, have_d;
  logic [15:0]        bval_q, bval_d;
  logic [7:0]         bw_q, bw_d, acc_q, acc_d;
  logic [23:0]        prod_q, prod_d;
  logic signed [9:0]  wcw_q, wcw_d;
  logic               zflag_q, zflag_d;
  logic               rfound_q, rfound_d;
  logic [IW-1:0]      rnode_q, rnode_d;
  logic               ovalid_q, ovalid_d, ofound_q, ofound_d;
  logic [IW-1:0]      onode_q, onode_d;

  slb_pkg::tbl_wr_t tbl_wr;
  slb_pkg::tbl_rd_t rd;
  logic [IW-1:0]    rd_addr;

  logic          mod_start, mod_done, gcd_start, gcd_done;
  logic [31:0]   mod_dvd;
  logic [IW-1:0] mod_rem;
  logic [7:0]    gcd_g, g_new, m_new;

  logic [NW-1:0] n_w;
  logic [SW-1:0] limit;
  logic [IW-1:0] nxt_idx;
  logic          sidx_last, use_conn, weighted;
  logic [15:0]   val;
  logic [23:0]   rhs;

  // entries in use saturate at the table size
  assign n_w       = (ncnt_q > NW'(slb_pkg::NODES)) ? NW'(slb_pkg::NODES) : ncnt_q;
  assign limit     = SW'(n_w) * SW'(slb_pkg::WRR_LAPS);
  assign nxt_idx   = (({1'b0, idx_q} + NW'(1)) == n_w) ? '0 : idx_q + IW'(1);
  assign sidx_last = (({1'b0, sidx_q} + NW'(1)) == n_w);
  assign use_conn  = (mode_q == slb_pkg::POL_LC) || (mode_q == slb_pkg::POL_WLC);
  assign weighted  = (mode_q == slb_pkg::POL_WLC) || (mode_q == slb_pkg::POL_WLV);
  assign val       = use_conn ? rd.conn : rd.load;
  assign rhs       = 24'(bval_q) * 24'(rd.weight);
  assign g_new     = zflag_q ? 8'd1 : gcd_g;
  assign m_new     = (rd.weight > acc_q) ? rd.weight : acc_q;

  slb_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (tbl_wr),
    .rd_addr_i(rd_addr),
    .rd_o     (rd)
  );

  slb_modn u_modn (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start_i(mod_start),
    .dvd_i (mod_dvd),
    .div_i (n_w),
    .done_o(mod_done),
    .rem_o (mod_rem)
  );

  slb_gcd u_gcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(gcd_start),
    .a_i    (acc_q),
    .b_i    (rd.weight),
    .done_o (gcd_done),
    .g_o    (gcd_g)
  );

  always_comb begin
    state_d  = state_q;
    mode_d   = mode_q;
    ncnt_d   = ncnt_q;
    last_d   = last_q;
    cw_d     = cw_q;
    gcd_d    = gcd_q;
    gval_d   = gval_q;
    maxw_d   = maxw_q;
    mval_d   = mval_q;
    idx_d    = idx_q;
    sidx_d   = sidx_q;
    best_d   = best_q;
    cnt_d    = cnt_q;
    have_d   = have_q;
    bval_d   = bval_q;
    bw_d     = bw_q;
    acc_d    = acc_q;
    prod_d   = prod_q;
    wcw_d    = wcw_q;
    zflag_d  = zflag_q;
    rfound_d = rfound_q;
    rnode_d  = rnode_q;
    ovalid_d = ovalid_q;
    ofound_d = ofound_q;
    onode_d  = onode_q;
    mod_start = 1'b0;
    mod_dvd   = '0;
    gcd_start = 1'b0;
    tbl_wr    = '0;
    rd_addr   = idx_q;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        slb_pkg::CFG_POLICY: mode_d = cfg_data_i[2:0];
        slb_pkg::CFG_NODES:  ncnt_d = cfg_data_i[NW-1:0];
        default: ;
      endcase
    end

    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          rfound_d = 1'b0;
          rnode_d  = '0;
          state_d  = ST_DONE;
          case (command_i)
            slb_pkg::CMD_UPDATE: begin
              tbl_wr.en     = 1'b1;
              tbl_wr.slot   = node_slot_i;
              tbl_wr.act    = node_enabled_i;
              tbl_wr.weight = node_weight_in_i;
              tbl_wr.conn   = node_conn_in_i;
              tbl_wr.load   = node_load_in_i;
            end
            slb_pkg::CMD_RESET: begin
              last_d = '0;
              cw_d   = '0;
              gcd_d  = '0;
              gval_d = 1'b0;
              maxw_d = '0;
              mval_d = 1'b0;
            end
            slb_pkg::CMD_SELECT: begin
              if (n_w != '0) begin
                case (mode_q)
                  slb_pkg::POL_RR, slb_pkg::POL_WRR: begin
                    mod_start = 1'b1;
                    mod_dvd   = 32'(last_q) + 32'd1;
                    state_d   = ST_MOD;
                  end
                  slb_pkg::POL_HASH: begin
                    mod_start = 1'b1;
                    mod_dvd   = hash_value_i;
                    state_d   = ST_MOD;
                  end
                  slb_pkg::POL_LC, slb_pkg::POL_WLC,
                  slb_pkg::POL_LV, slb_pkg::POL_WLV: begin
                    idx_d   = IW'(n_w - NW'(1));
                    have_d  = 1'b0;
                    state_d = ST_MIN_A;
                  end
                  default: ;
                endcase
              end
            end
            default: ;
          endcase
        end
      end

      ST_MOD: begin
        if (mod_done) begin
          idx_d   = mod_rem;
          cnt_d   = '0;
          wcw_d   = $signed({1'b0, cw_q});
          state_d = (mode_q == slb_pkg::POL_WRR) ? ST_WRR_Z : ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (rd.act) begin
          rfound_d = 1'b1;
          rnode_d  = idx_q;
          state_d  = ST_DONE;
        end else if ((cnt_q + SW'(1)) == SW'(n_w)) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + SW'(1);
          idx_d = nxt_idx;
        end
      end

      // wrap to entry 0 lowers the weight threshold by the gcd
      ST_WRR_Z: begin
        if (idx_q != '0) begin
          state_d = ST_WRR_CHK;
        end else if (gval_q) begin
          wcw_d   = wcw_q - $signed({2'b0, gcd_q});
          state_d = ST_WRR_CW;
        end else begin
          sidx_d  = '0;
          acc_d   = '0;
          zflag_d = 1'b0;
          state_d = ST_GCD_LD;
        end
      end

      ST_GCD_LD: begin
        rd_addr   = sidx_q;
        gcd_start = 1'b1;
        if (rd.weight == 8'd0) zflag_d = 1'b1;
        state_d = ST_GCD_RUN;
      end

      ST_GCD_RUN: begin
        rd_addr = sidx_q;
        if (gcd_done) begin
          acc_d = gcd_g;
          if (sidx_last) begin
            gcd_d   = g_new;
            gval_d  = 1'b1;
            wcw_d   = wcw_q - $signed({2'b0, g_new});
            state_d = ST_WRR_CW;
          end else begin
            sidx_d  = sidx_q + IW'(1);
            state_d = ST_GCD_LD;
          end
        end
      end

      ST_WRR_CW: begin
        if (wcw_q <= 10'sd0) begin
          if (mval_q) begin
            wcw_d   = $signed({2'b0, maxw_q});
            state_d = ST_WRR_CHK;
          end else begin
            sidx_d  = '0;
            acc_d   = '0;
            state_d = ST_MAX;
          end
        end else begin
          state_d = ST_WRR_CHK;
        end
      end

      ST_MAX: begin
        rd_addr = sidx_q;
        if (sidx_last) begin
          maxw_d  = m_new;
          mval_d  = (m_new != 8'd0);
          wcw_d   = $signed({2'b0, m_new});
          state_d = (m_new == 8'd0) ? ST_DONE : ST_WRR_CHK;
        end else begin
          acc_d  = m_new;
          sidx_d = sidx_q + IW'(1);
        end
      end

      ST_WRR_CHK: begin
        if (rd.act && ($signed({2'b0, rd.weight}) >= wcw_q)) begin
          cw_d     = wcw_q[8:0];
          rfound_d = 1'b1;
          rnode_d  = idx_q;
          state_d  = ST_DONE;
        end else if ((cnt_q + SW'(1)) == limit) begin
          state_d = ST_DONE;
        end else begin
          cnt_d   = cnt_q + SW'(1);
          idx_d   = nxt_idx;
          state_d = ST_WRR_Z;
        end
      end

      // downward scan, ties fall to the lower index
      ST_MIN_A: begin
        state_d = ST_MIN_NX;
        if (rd.act) begin
          if (!have_q) begin
            have_d = 1'b1;
            best_d = idx_q;
            bval_d = val;
            bw_d   = rd.weight;
          end else if (weighted) begin
            prod_d  = 24'(val) * 24'(bw_q);
            state_d = ST_MIN_B;
          end else if (val <= bval_q) begin
            best_d = idx_q;
            bval_d = val;
            bw_d   = rd.weight;
          end
        end
      end

      ST_MIN_B: begin
        if (prod_q <= rhs) begin
          best_d = idx_q;
          bval_d = val;
          bw_d   = rd.weight;
        end
        state_d = ST_MIN_NX;
      end

      ST_MIN_NX: begin
        if (idx_q == '0) begin
          rfound_d = have_q;
          rnode_d  = have_q ? best_q : '0;
          state_d  = ST_DONE;
        end else begin
          idx_d   = idx_q - IW'(1);
          state_d = ST_MIN_A;
        end
      end

      ST_DONE: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d = 1'b1;
          ofound_d = rfound_q;
          onode_d  = rnode_q;
          if (rfound_q) last_d = rnode_q;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      mode_q   <= '0;
      ncnt_q   <= '0;
      last_q   <= '0;
      cw_q     <= '0;
      gcd_q    <= '0;
      gval_q   <= 1'b0;
      maxw_q   <= '0;
      mval_q   <= 1'b0;
      idx_q    <= '0;
      sidx_q   <= '0;
      best_q   <= '0;
      cnt_q    <= '0;
      have_q   <= 1'b0;
      bval_q   <= '0;
      bw_q     <= '0;
      acc_q    <= '0;
      prod_q   <= '0;
      wcw_q    <= '0;
      zflag_q  <= 1'b0;
      rfound_q <= 1'b0;
      rnode_q  <= '0;
      ovalid_q <= 1'b0;
      ofound_q <= 1'b0;
      onode_q  <= '0;
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      ncnt_q   <= ncnt_d;
      last_q   <= last_d;
      cw_q     <= cw_d;
      gcd_q    <= gcd_d;
      gval_q   <= gval_d;
      maxw_q   <= maxw_d;
      mval_q   <= mval_d;
      idx_q    <= idx_d;
      sidx_q   <= sidx_d;
      best_q   <= best_d;
      cnt_q    <= cnt_d;
      have_q   <= have_d;
      bval_q   <= bval_d;
      bw_q     <= bw_d;
      acc_q    <= acc_d;
      prod_q   <= prod_d;
      wcw_q    <= wcw_d;
      zflag_q  <= zflag_d;
      rfound_q <= rfound_d;
      rnode_q  <= rnode_d;
      ovalid_q <= ovalid_d;
      ofound_q <= ofound_d;
      onode_q  <= onode_d;
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign in_ready_o    = (state_q == ST_IDLE);
  assign out_valid_o   = ovalid_q;
  assign found_o       = ofound_q;
  assign chosen_node_o = onode_q;

`include "assert_macros.svh"

  `SLB_ASSERT_NEXT(a_busy_after_beat, in_valid_i && in_ready_o, !in_ready_o, "ready after beat")
  `SLB_ASSERT(a_gcd_nonzero, !gval_q || (gcd_q != 8'd0), "cached gcd is zero")
  `SLB_ASSERT(a_max_nonzero, !mval_q || (maxw_q != 8'd0), "cached max weight is zero")
  `SLB_ASSERT(a_cw_range, !cw_q[8], "current weight above 255")

endmodule
`default_nettype wire

// ===== tb/sv/tb_server_load_balancer_select.sv =====
`default_nettype none
module tb_server_load_balancer_select;
  import slb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The slowest legal wrr select is far below this cap, so the cap is generous.
  localparam longint unsigned CYCLE_CAP  = 100_000_000;
  localparam int              PHASES     = 20;
  localparam int              PHASE_LEN  = 40;
  localparam int              TAIL_WAIT  = 64;
  localparam int              HOLD_LEN   = 600;

  // Predicts the found flag and the chosen node for each command.
  class pick_tracker;
    typedef struct packed {
      bit       found;
      bit [3:0] node;
    } pick_t;

    bit [2:0]  mode;
    bit [4:0]  ncfg;
    bit        act  [NODES];
    bit [7:0]  wt   [NODES];
    bit [15:0] conn [NODES];
    bit [15:0] load [NODES];
    bit [3:0]  last_idx;
    int        cur_w;
    bit [7:0]  gcd_c;
    bit [7:0]  max_c;
    bit        gcd_ok;
    bit        max_ok;
    pick_t     exp_q[$];
    int        errors;

    function void set_reg(bit [1:0] idx, bit [7:0] d);
      if (idx == CFG_POLICY) mode = d[2:0];
      else if (idx == CFG_NODES) ncfg = d[4:0];
    endfunction

    function int pending();
      return exp_q.size();
    endfunction

    // Largest divisor of every weight in 0..n-1; a zero weight forces 1.
    function bit [7:0] calc_gcd(int n);
      int unsigned g;
      bit          common;
      g = 255;
      for (int i = 0; i < n; i++) if (wt[i] < g) g = wt[i];
      common = 0;
      while (g >= 1 && !common) begin
        common = 1;
        for (int i = 0; i < n; i++) if (wt[i] % g != 0) common = 0;
        if (!common) g--;
      end
      return (g == 0) ? 8'd1 : g[7:0];
    endfunction

    function bit [7:0] calc_max(int n);
      bit [7:0] m;
      m = 0;
      for (int i = 0; i < n; i++) if (wt[i] > m) m = wt[i];
      return m;
    endfunction

    function bit pick_wrr(int n, output int unsigned p);
      int unsigned idx;
      int          cw;
      idx = last_idx;
      cw  = cur_w;
      p   = 0;
      for (int s = 0; s < n * WRR_LAPS; s++) begin
        idx = (idx + 1) % n;
        if (idx == 0) begin
          if (!gcd_ok) begin
            gcd_c  = calc_gcd(n);
            gcd_ok = 1;
          end
          cw -= int'(gcd_c);
          if (cw <= 0) begin
            if (!max_ok) begin
              max_c  = calc_max(n);
              max_ok = (max_c > 0);
            end
            cw = int'(max_c);
            if (cw == 0) return 0;
          end
        end
        if (act[idx] && int'(wt[idx]) >= cw) begin
          cur_w = cw;
          p     = idx;
          return 1;
        end
      end
      return 0;
    endfunction

    function bit pick_scan(int n, int unsigned start, output int unsigned p);
      int unsigned idx;
      p = 0;
      for (int k = 0; k < n; k++) begin
        idx = (start + k) % n;
        if (act[idx]) begin
          p = idx;
          return 1;
        end
      end
      return 0;
    endfunction

    // Walks down from n-1 so ties settle on the lower index.
    function bit pick_min(int n, bit use_load, bit weighted, output int unsigned p);
      int unsigned     best;
      bit              have;
      longint unsigned lhs, rhs, vi, vb;
      best = 0;
      have = 0;
      for (int i = n - 1; i >= 0; i--) begin
        if (act[i]) begin
          vi = use_load ? load[i] : conn[i];
          vb = use_load ? load[best] : conn[best];
          if (!have) begin
            have = 1;
            best = i;
          end else if (weighted) begin
            lhs = vi * wt[best];
            rhs = vb * wt[i];
            if (lhs <= rhs) best = i;
          end else if (vi <= vb) begin
            best = i;
          end
        end
      end
      p = best;
      return have;
    endfunction

    function void note_command(bit [1:0] cmd, bit [3:0] slot, bit en, bit [7:0] w,
                               bit [15:0] c, bit [15:0] l, bit [31:0] h);
      pick_t       r;
      int          n;
      int unsigned p;
      bit          ok;
      r  = '0;
      ok = 0;
      p  = 0;
      n  = (ncfg > NODES) ? NODES : ncfg;
      if (cmd == CMD_UPDATE) begin
        act[slot]  = en;
        wt[slot]   = w;
        conn[slot] = c;
        load[slot] = l;
      end else if (cmd == CMD_RESET) begin
        last_idx = 0;
        cur_w    = 0;
        gcd_c    = 0;
        max_c    = 0;
        gcd_ok   = 0;
        max_ok   = 0;
      end else if (cmd == CMD_SELECT && n != 0) begin
        case (mode)
          POL_RR:   ok = pick_scan(n, (last_idx + 1) % n, p);
          POL_WRR:  ok = pick_wrr(n, p);
          POL_LC:   ok = pick_min(n, 1'b0, 1'b0, p);
          POL_WLC:  ok = pick_min(n, 1'b0, 1'b1, p);
          POL_LV:   ok = pick_min(n, 1'b1, 1'b0, p);
          POL_WLV:  ok = pick_min(n, 1'b1, 1'b1, p);
          POL_HASH: ok = pick_scan(n, h % n, p);
          default:  ok = 0;
        endcase
        if (ok) begin
          last_idx = p[3:0];
          r.found  = 1;
          r.node   = p[3:0];
        end
      end
      exp_q.push_back(r);
    endfunction

    function void check_pick(bit found, bit [3:0] node);
      pick_t e;
      if (exp_q.size() == 0) begin
        $error("result beat with nothing expected: found=%0d node=%0d", found, node);
        errors++;
        return;
      end
      e = exp_q.pop_front();
      if (found !== e.found) begin
        $error("found: expected %0d, got %0d", e.found, found);
        errors++;
      end
      if (node !== e.node) begin
        $error("chosen_node: expected %0d, got %0d", e.node, node);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        cfg_valid_i      = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i      = '0;
  logic [7:0]  cfg_data_i       = '0;
  logic        in_valid_i       = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i        = '0;
  logic [3:0]  node_slot_i      = '0;
  logic        node_enabled_i   = 1'b0;
  logic [7:0]  node_weight_in_i = '0;
  logic [15:0] node_conn_in_i   = '0;
  logic [15:0] node_load_in_i   = '0;
  logic [31:0] hash_value_i     = '0;
  logic        out_valid_o;
  logic        out_ready_i      = 1'b0;
  logic        found_o;
  logic [3:0]  chosen_node_o;

  pick_tracker     picks = new();
  longint unsigned cycles = 0;
  bit              hold_now = 0;   // asks the sink for one long hold-off
  bit              no_idle  = 0;   // phase with both sides flat out
  int              sink_stall = 0;

  server_load_balancer_select DUT (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("tb_server_load_balancer_select: done, errors");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // sink: random stalls, plus one long counted hold-off on request
  always @(posedge clk_i) begin
    if (hold_now) begin
      hold_now    <= 0;
      sink_stall  <= HOLD_LEN;
      out_ready_i <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall  <= sink_stall - 1;
      out_ready_i <= 1'b0;
    end else if (gap_len() > 0) begin
      sink_stall  <= gap_len();
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // beat monitor: values seen here are the ones before this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) picks.check_pick(found_o, chosen_node_o);
      if (in_valid_i && in_ready_o)
        picks.note_command(command_i, node_slot_i, node_enabled_i, node_weight_in_i,
                           node_conn_in_i, node_load_in_i, hash_value_i);
    end
  end

  // both registers back to back, valid held across the two beats
  task automatic write_regs(bit [7:0] pol, bit [7:0] cnt);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_POLICY;
    cfg_data_i  <= pol;
    do @(posedge clk_i); while (!cfg_ready_o);
    picks.set_reg(CFG_POLICY, pol);
    cfg_index_i <= CFG_NODES;
    cfg_data_i  <= cnt;
    do @(posedge clk_i); while (!cfg_ready_o);
    picks.set_reg(CFG_NODES, cnt);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_cmd(bit [1:0] cmd, bit [3:0] slot, bit en, bit [7:0] w,
                          bit [15:0] c, bit [15:0] l, bit [31:0] h);
    int g;
    in_valid_i       <= 1'b1;
    command_i        <= cmd;
    node_slot_i      <= slot;
    node_enabled_i   <= en;
    node_weight_in_i <= w;
    node_conn_in_i   <= c;
    node_load_in_i   <= l;
    hash_value_i     <= h;
    do @(posedge clk_i); while (!in_ready_o);
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // sender pause: no beat in flight, every result back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (picks.pending() != 0) @(posedge clk_i);
  endtask

  function automatic bit [7:0] rand_weight();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      2, 3, 4: return 8'($urandom_range(1, 4) * 6);  // shared factors for the gcd
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic bit [15:0] rand_metric();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(0, 7));    // ties
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random();
    int r;
    r = $urandom_range(0, 99);
    if (r < 58)
      send_cmd(CMD_SELECT, 4'($urandom), 1'($urandom), 8'($urandom), 16'($urandom),
               16'($urandom), $urandom);
    else if (r < 90)
      send_cmd(CMD_UPDATE, 4'($urandom), ($urandom_range(0, 9) < 7), rand_weight(),
               rand_metric(), rand_metric(), $urandom);
    else if (r < 95)
      send_cmd(CMD_RESET, 4'($urandom), 1'($urandom), 8'($urandom), 16'($urandom),
               16'($urandom), $urandom);
    else
      send_cmd(2'd3, 4'($urandom), 1'($urandom), 8'($urandom), 16'($urandom),
               16'($urandom), $urandom);
  endtask

  initial begin
    bit [7:0] pol, cnt;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: fill every entry first, so no unwritten weight is ever read.
    write_regs(POL_WLC, 8'd16);
    for (int i = 0; i < NODES; i++)
      send_cmd(CMD_UPDATE, 4'(i), (i % 3 != 1), (i == 0) ? 8'd255 : (i == 5) ? 8'd1 : 8'(12 * i),
               (i == 2) ? 16'hFFFF : 16'(i * 100), (i == 4) ? 16'd0 : 16'hFFFF, '0);
    send_cmd(CMD_SELECT, '0, 1'b0, '0, '0, '0, 32'hFFFF_FFFF);
    send_cmd(2'd3, 4'hF, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_cmd(CMD_RESET, '0, 1'b0, '0, '0, '0, '0);
    drain();
    write_regs(POL_HASH, 8'd31);   // count saturates to the table size
    send_cmd(CMD_SELECT, '0, 1'b0, '0, '0, '0, 32'hFFFF_FFFF);
    send_cmd(CMD_SELECT, '0, 1'b0, '0, '0, '0, 32'h0000_0000);
    drain();
    write_regs(8'd7, 8'd16);       // undefined policy
    send_cmd(CMD_SELECT, '0, 1'b0, '0, '0, '0, '0);
    drain();
    write_regs(POL_WRR, 8'd0);     // empty table in use
    send_cmd(CMD_SELECT, '0, 1'b0, '0, '0, '0, '0);
    drain();

    // Random phases: every policy in turn first, then random settings.
    for (int ph = 0; ph < PHASES; ph++) begin
      pol = (ph < 8) ? 8'(ph) : 8'($urandom_range(0, 7));
      case ($urandom_range(0, 5))
        0:       cnt = 8'd16;
        1:       cnt = 8'd31;
        2:       cnt = 8'($urandom_range(0, 2));
        default: cnt = 8'($urandom_range(1, 20));
      endcase
      if (ph == 0) pol = 8'(POL_RR) | 8'hF8;  // upper data bits are don't care
      write_regs(pol, cnt);
      no_idle = (ph % 5 == 4);
      if (ph == 1) hold_now = 1;             // sink holds off while we keep sending
      for (int k = 0; k < PHASE_LEN; k++) send_random();
      drain();
    end

    repeat (TAIL_WAIT) @(posedge clk_i);
    if (picks.errors == 0 && picks.pending() == 0)
      $display("tb_server_load_balancer_select: done, clean");
    else
      $display("tb_server_load_balancer_select: done, errors");
    $finish;
  end

endmodule
`default_nettype wire
